// ===== design/hsb_color_fade_interpolator_assert.svh =====
// Assertion macros for the HSB color fade interpolator.
`ifndef HSB_COLOR_FADE_INTERPOLATOR_ASSERT_SVH
`define HSB_COLOR_FADE_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define HCFI_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("hcfi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HCFI_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("hcfi assertion failed");

`else

`define HCFI_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define HCFI_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== design/hcfi_pkg.sv =====
// Package for the HSB color fade interpolator: types and constants.
package hcfi_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int NUM_CH  = 5;
    localparam int CH_HUE  = 0;
    localparam int CH_SAT  = 1;
    localparam int CH_BRI  = 2;
    localparam int CH_W1   = 3;
    localparam int CH_W2   = 4;

    localparam int Q_BITS   = 7;   // percent quotient 0..99
    localparam int DIV_STG  = Q_BITS;

    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [12:0] RECIP_100   = 13'd5243;  // ceil(2^19 / 100)
    localparam int          RECIP_SHIFT = 19;
    localparam logic [17:0] ROUND_99    = 18'd99;

    localparam logic signed [10:0] HUE_HALF = 11'sd180;
    localparam logic signed [10:0] HUE_FULL = 11'sd360;

    typedef enum logic [2:0] {
        REG_TARGET_HUE  = 3'd0,
        REG_TARGET_SAT  = 3'd1,
        REG_TARGET_BRI  = 3'd2,
        REG_TARGET_W1   = 3'd3,
        REG_TARGET_W2   = 3'd4,
        REG_START_TIME  = 3'd5,
        REG_DURATION    = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [NUM_CH-1:0][8:0] from;
        logic [NUM_CH-1:0][9:0] diff;   // signed target minus source, hue on short path
    } t_color;

    typedef struct packed {
        logic early;    // now earlier than start
        logic ge;       // elapsed >= duration
        logic done;     // elapsed > duration
    } t_flags;

endpackage

// ===== design/hsb_color_fade_interpolator.sv =====
// HSB color fade interpolator: pipelined percent divider and channel blend.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  input   | i_valid / o_stall          | i_now_time, i_from_hue, i_from_* levels
//  output  | o_valid / i_stall          | o_out_hue, o_out_* levels, o_completed
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while i_stall is low; twelve register
// stages in all. Seven of the stages are the restoring division that produces
// the percent, one quotient bit each.
// Synchronous active-low reset clears stage valid bits and the configuration registers.
// Stages advance whenever the next one is empty or moving, so bubbles collapse
// and input is taken while a result waits on a stalled output.
`include "hsb_color_fade_interpolator_assert.svh"

module hsb_color_fade_interpolator #(
    parameter int TIME_BITS = hcfi_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [TIME_BITS-1:0] i_now_time,
    input  logic [8:0]           i_from_hue,
    input  logic [6:0]           i_from_saturation,
    input  logic [6:0]           i_from_brightness,
    input  logic [6:0]           i_from_white_one,
    input  logic [6:0]           i_from_white_two,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [8:0]           o_out_hue,
    output logic [6:0]           o_out_saturation,
    output logic [6:0]           o_out_brightness,
    output logic [6:0]           o_out_white_one,
    output logic [6:0]           o_out_white_two,
    output logic                 o_completed,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [TIME_BITS-1:0] i_cfg_data
);

    localparam int NCH  = hcfi_pkg::NUM_CH;
    localparam int NDIV = hcfi_pkg::DIV_STG;
    localparam int RW   = TIME_BITS + hcfi_pkg::Q_BITS;
    localparam int S_IN  = 0;
    localparam int S_CMP = 1;
    localparam int S_DV0 = 2;
    localparam int S_MUL = S_DV0 + NDIV;
    localparam int S_REC = S_MUL + 1;
    localparam int S_OUT = S_REC + 1;
    localparam int NSTG  = S_OUT + 1;

    // ---------------- configuration ----------------
    logic [8:0]           r_tgt_hue;
    logic [6:0]           r_tgt_sat, r_tgt_bri, r_tgt_w1, r_tgt_w2;
    logic [TIME_BITS-1:0] r_start, r_duration;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_hue  <= '0;
            r_tgt_sat  <= '0;
            r_tgt_bri  <= '0;
            r_tgt_w1   <= '0;
            r_tgt_w2   <= '0;
            r_start    <= '0;
            r_duration <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (hcfi_pkg::t_cfg_reg'(i_cfg_index))
                hcfi_pkg::REG_TARGET_HUE: r_tgt_hue  <= i_cfg_data[8:0];
                hcfi_pkg::REG_TARGET_SAT: r_tgt_sat  <= i_cfg_data[6:0];
                hcfi_pkg::REG_TARGET_BRI: r_tgt_bri  <= i_cfg_data[6:0];
                hcfi_pkg::REG_TARGET_W1:  r_tgt_w1   <= i_cfg_data[6:0];
                hcfi_pkg::REG_TARGET_W2:  r_tgt_w2   <= i_cfg_data[6:0];
                hcfi_pkg::REG_START_TIME: r_start    <= i_cfg_data;
                hcfi_pkg::REG_DURATION:   r_duration <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[S_IN];
    assign o_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == S_IN) ? i_valid : r_vld[(k == S_IN) ? 0 : k - 1];
                end
            end
        end
    end

    // ---------------- stage 0: elapsed time, channel differences ----------------
    logic [TIME_BITS:0]    w_elapsed;
    hcfi_pkg::t_color      w_col_in;
    logic [NCH-1:0][8:0]   w_tgt;
    logic signed [10:0]    w_dh;
    logic signed [10:0]    w_dh_adj;
    logic signed [10:0]    w_dl;

    logic [TIME_BITS-1:0]  r_s0_elapsed;
    logic                  r_s0_before;
    hcfi_pkg::t_color      r_s0_col;

    assign w_elapsed = {1'b0, i_now_time} - {1'b0, r_start};

    always_comb begin
        w_tgt[hcfi_pkg::CH_HUE] = r_tgt_hue;
        w_tgt[hcfi_pkg::CH_SAT] = {2'b00, r_tgt_sat};
        w_tgt[hcfi_pkg::CH_BRI] = {2'b00, r_tgt_bri};
        w_tgt[hcfi_pkg::CH_W1]  = {2'b00, r_tgt_w1};
        w_tgt[hcfi_pkg::CH_W2]  = {2'b00, r_tgt_w2};
        w_col_in.from[hcfi_pkg::CH_HUE] = i_from_hue;
        w_col_in.from[hcfi_pkg::CH_SAT] = {2'b00, i_from_saturation};
        w_col_in.from[hcfi_pkg::CH_BRI] = {2'b00, i_from_brightness};
        w_col_in.from[hcfi_pkg::CH_W1]  = {2'b00, i_from_white_one};
        w_col_in.from[hcfi_pkg::CH_W2]  = {2'b00, i_from_white_two};

        // hue goes the short way round; the adjusted difference stays within +-180
        w_dh = $signed({2'b00, w_tgt[hcfi_pkg::CH_HUE]})
             - $signed({2'b00, w_col_in.from[hcfi_pkg::CH_HUE]});
        if (w_dh > hcfi_pkg::HUE_HALF) begin
            w_dh_adj = w_dh - hcfi_pkg::HUE_FULL;
        end else if (w_dh < -hcfi_pkg::HUE_HALF) begin
            w_dh_adj = w_dh + hcfi_pkg::HUE_FULL;
        end else begin
            w_dh_adj = w_dh;
        end
        w_col_in.diff[hcfi_pkg::CH_HUE] = w_dh_adj[9:0];

        w_dl = '0;
        for (int c = 1; c < NCH; c++) begin
            w_dl = $signed({2'b00, w_tgt[c]}) - $signed({2'b00, w_col_in.from[c]});
            w_col_in.diff[c] = w_dl[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_IN]) begin
            r_s0_elapsed <= w_elapsed[TIME_BITS-1:0];
            r_s0_before  <= w_elapsed[TIME_BITS];
            r_s0_col     <= w_col_in;
        end
    end

    // ---------------- stage 1: duration compare, numerator 100 * elapsed ----------------
    logic [TIME_BITS:0]    w_cmp;
    logic [RW-1:0]         w_e_ext;
    logic [RW-1:0]         r_s1_num;
    hcfi_pkg::t_flags      r_s1_flg;
    hcfi_pkg::t_color      r_s1_col;

    assign w_cmp   = {1'b0, r_s0_elapsed} - {1'b0, r_duration};
    assign w_e_ext = {{hcfi_pkg::Q_BITS{1'b0}}, r_s0_elapsed};

    always_ff @(posedge i_clk) begin
        if (w_adv[S_CMP]) begin
            r_s1_num        <= (w_e_ext << 6) + (w_e_ext << 5) + (w_e_ext << 2);
            r_s1_flg.early  <= r_s0_before;
            r_s1_flg.ge     <= !w_cmp[TIME_BITS];
            r_s1_flg.done   <= !r_s0_before && !w_cmp[TIME_BITS]
                            && (w_cmp[TIME_BITS-1:0] != '0);
            r_s1_col        <= r_s0_col;
        end
    end

    // ---------------- stages 2..8: restoring division, one quotient bit each ----------------
    logic [RW-1:0]                  r_d_rem [NDIV];
    logic [hcfi_pkg::Q_BITS-1:0]    r_d_q   [NDIV];
    hcfi_pkg::t_flags               r_d_flg [NDIV];
    hcfi_pkg::t_color               r_d_col [NDIV];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        logic [RW-1:0]               w_rem_in;
        logic [hcfi_pkg::Q_BITS-1:0] w_q_in;
        hcfi_pkg::t_flags            w_flg_in;
        hcfi_pkg::t_color            w_col_in_d;
        logic [RW-1:0]               w_dsh;
        logic [RW:0]                 w_sub;

        if (j == 0) begin : g_first
            assign w_rem_in   = r_s1_num;
            assign w_q_in     = '0;
            assign w_flg_in   = r_s1_flg;
            assign w_col_in_d = r_s1_col;
        end else begin : g_next
            assign w_rem_in   = r_d_rem[j-1];
            assign w_q_in     = r_d_q[j-1];
            assign w_flg_in   = r_d_flg[j-1];
            assign w_col_in_d = r_d_col[j-1];
        end

        assign w_dsh = {{hcfi_pkg::Q_BITS{1'b0}}, r_duration} << (NDIV - 1 - j);
        assign w_sub = {1'b0, w_rem_in} - {1'b0, w_dsh};

        always_ff @(posedge i_clk) begin
            if (w_adv[S_DV0 + j]) begin
                r_d_rem[j] <= w_sub[RW] ? w_rem_in : w_sub[RW-1:0];
                r_d_q[j]   <= {w_q_in[hcfi_pkg::Q_BITS-2:0], !w_sub[RW]};
                r_d_flg[j] <= w_flg_in;
                r_d_col[j] <= w_col_in_d;
            end
        end
    end

    // ---------------- stage 9: percent select, difference times percent ----------------
    logic [6:0]                 w_pct;
    logic signed [17:0]         r_s9_x    [NCH];
    logic [NCH-1:0][8:0]        r_s9_from;
    logic                       r_s9_done;

    always_comb begin
        if (r_d_flg[NDIV-1].early) begin
            w_pct = '0;
        end else if (r_d_flg[NDIV-1].ge) begin
            w_pct = hcfi_pkg::PCT_FULL;
        end else begin
            w_pct = r_d_q[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_MUL]) begin
            for (int c = 0; c < NCH; c++) begin
                r_s9_x[c] <= $signed(r_d_col[NDIV-1].diff[c]) * $signed({1'b0, w_pct});
            end
            r_s9_from <= r_d_col[NDIV-1].from;
            r_s9_done <= r_d_flg[NDIV-1].done;
        end
    end

    // ---------------- stage 10: floor division by 100 via reciprocal ----------------
    logic [17:0]                w_mag     [NCH];
    logic [27:0]                r_s10_prod [NCH];
    logic [NCH-1:0]             r_s10_neg;
    logic [NCH-1:0][8:0]        r_s10_from;
    logic                       r_s10_done;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            // negative: floor(x/100) = -floor((|x| + 99) / 100)
            w_mag[c] = r_s9_x[c][17] ? (18'(-r_s9_x[c]) + hcfi_pkg::ROUND_99)
                                     : 18'(r_s9_x[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_REC]) begin
            for (int c = 0; c < NCH; c++) begin
                r_s10_prod[c] <= 28'(w_mag[c][14:0]) * 28'(hcfi_pkg::RECIP_100);
                r_s10_neg[c]  <= r_s9_x[c][17];
            end
            r_s10_from <= r_s9_from;
            r_s10_done <= r_s9_done;
        end
    end

    // ---------------- stage 11: add source, wrap hue, output register ----------------
    logic [8:0]                 w_qd  [NCH];
    logic signed [10:0]         w_sum [NCH];
    logic signed [10:0]         w_hue;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_qd[c]  = r_s10_prod[c][hcfi_pkg::RECIP_SHIFT +: 9];
            w_sum[c] = r_s10_neg[c]
                     ? $signed({2'b00, r_s10_from[c]}) - $signed({2'b00, w_qd[c]})
                     : $signed({2'b00, r_s10_from[c]}) + $signed({2'b00, w_qd[c]});
        end
        // blended hue lies in -180..691, one correction reaches 0..359
        if (w_sum[hcfi_pkg::CH_HUE] < 0) begin
            w_hue = w_sum[hcfi_pkg::CH_HUE] + hcfi_pkg::HUE_FULL;
        end else if (w_sum[hcfi_pkg::CH_HUE] >= hcfi_pkg::HUE_FULL) begin
            w_hue = w_sum[hcfi_pkg::CH_HUE] - hcfi_pkg::HUE_FULL;
        end else begin
            w_hue = w_sum[hcfi_pkg::CH_HUE];
        end
    end

    logic [8:0] r_out_hue;
    logic [6:0] r_out_sat, r_out_bri, r_out_w1, r_out_w2;
    logic       r_out_done;

    always_ff @(posedge i_clk) begin
        if (w_adv[S_OUT]) begin
            r_out_hue  <= w_hue[8:0];
            r_out_sat  <= w_sum[hcfi_pkg::CH_SAT][6:0];
            r_out_bri  <= w_sum[hcfi_pkg::CH_BRI][6:0];
            r_out_w1   <= w_sum[hcfi_pkg::CH_W1][6:0];
            r_out_w2   <= w_sum[hcfi_pkg::CH_W2][6:0];
            r_out_done <= r_s10_done;
        end
    end

    assign o_out_hue        = r_out_hue;
    assign o_out_saturation = r_out_sat;
    assign o_out_brightness = r_out_bri;
    assign o_out_white_one  = r_out_w1;
    assign o_out_white_two  = r_out_w2;
    assign o_completed      = r_out_done;

    // ---------------- assertions ----------------
    `HCFI_ASSERT_IMPL(a_hue_in_range, i_clk, i_rst_n, o_valid, r_out_hue < 9'd360)
    `HCFI_ASSERT_IMPL(a_empty_out_no_stall, i_clk, i_rst_n, !r_vld[S_OUT], !o_stall)
    `HCFI_ASSERT_IMPL(a_done_needs_full, i_clk, i_rst_n, r_vld[S_DV0],
                      !r_d_flg[0].done || (r_d_flg[0].ge && !r_d_flg[0].early))
    `HCFI_ASSERT_NEXT(a_stalled_result_kept, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule

// ===== verif/hsb_color_fade_interpolator_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the HSB color fade interpolator: directed and random fades against a predictor.
module hsb_color_fade_interpolator_tb;

    localparam int TB_TIME_BITS = hcfi_pkg::TIME_BITS_DEF;
    localparam int CLK_HALF = 4;
    localparam logic [2:0] REG_SPARE_IDX = 3'd7;    // past the register file, must be ignored
    localparam logic [TB_TIME_BITS-1:0] TIME_MAX = '1;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_ITEMS = 60;

    typedef logic [TB_TIME_BITS-1:0] t_stamp;

    typedef struct packed {
        t_stamp     now;
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bri;
        logic [6:0] w1;
        logic [6:0] w2;
    } t_pixel;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bri;
        logic [6:0] w1;
        logic [6:0] w2;
        t_stamp     start;
        t_stamp     dur;
    } t_fade_target;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] bri;
        logic [6:0] w1;
        logic [6:0] w2;
        logic       done;
    } t_out_color;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_stall;
    t_stamp       i_now_time = '0;
    logic [8:0]   i_from_hue = '0;
    logic [6:0]   i_from_saturation = '0;
    logic [6:0]   i_from_brightness = '0;
    logic [6:0]   i_from_white_one = '0;
    logic [6:0]   i_from_white_two = '0;
    logic         o_valid;
    logic         i_stall = 1'b0;
    logic [8:0]   o_out_hue;
    logic [6:0]   o_out_saturation;
    logic [6:0]   o_out_brightness;
    logic [6:0]   o_out_white_one;
    logic [6:0]   o_out_white_two;
    logic         o_completed;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    t_stamp       i_cfg_data = '0;

    t_fade_target live_target = '0;
    t_out_color   pending_colors[$];
    int           mismatch_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    bit           rx_holding = 1'b0;
    int           rx_burst = 0;
    event         rx_hold_go;

    hsb_color_fade_interpolator #(
        .TIME_BITS(TB_TIME_BITS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_now_time        (i_now_time),
        .i_from_hue        (i_from_hue),
        .i_from_saturation (i_from_saturation),
        .i_from_brightness (i_from_brightness),
        .i_from_white_one  (i_from_white_one),
        .i_from_white_two  (i_from_white_two),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_hue         (o_out_hue),
        .o_out_saturation  (o_out_saturation),
        .o_out_brightness  (o_out_brightness),
        .o_out_white_one   (o_out_white_one),
        .o_out_white_two   (o_out_white_two),
        .o_completed       (o_completed),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Color prediction
    // ------------------------------------------------------------------
    function automatic longint floor_hundredth(longint n);
        longint q;
        q = n / 100;
        if (n % 100 != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint mix_level(longint src, longint dst, longint pct);
        return floor_hundredth(src * 100 + (dst - src) * pct);
    endfunction

    function automatic t_out_color blend_color(t_pixel px, t_fade_target t);
        longint now_l, start_l, dur_l, elapsed, pct, src_hue, dst_hue, lvl;
        t_out_color c;
        now_l = px.now;
        start_l = t.start;
        dur_l = t.dur;
        if (now_l < start_l) begin
            pct = 0;
            c.done = 1'b0;
        end else begin
            elapsed = now_l - start_l;
            pct = (elapsed >= dur_l) ? 100 : elapsed * 100 / dur_l;
            c.done = elapsed > dur_l;
        end
        // hue goes the short way round; a difference of exactly 180 stays put
        src_hue = px.hue;
        dst_hue = t.hue;
        if (dst_hue - src_hue > 180) dst_hue -= 360;
        else if (dst_hue - src_hue < -180) dst_hue += 360;
        lvl = mix_level(src_hue, dst_hue, pct) % 360;
        if (lvl < 0) lvl += 360;
        c.hue = lvl[8:0];
        lvl = mix_level(px.sat, t.sat, pct);
        c.sat = lvl[6:0];
        lvl = mix_level(px.bri, t.bri, pct);
        c.bri = lvl[6:0];
        lvl = mix_level(px.w1, t.w1, pct);
        c.w1 = lvl[6:0];
        lvl = mix_level(px.w2, t.w2, pct);
        c.w2 = lvl[6:0];
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_pixel mk_pixel(t_stamp now, int h, int s, int b, int w1, int w2);
        t_pixel px;
        px.now = now;
        px.hue = 9'(h);
        px.sat = 7'(s);
        px.bri = 7'(b);
        px.w1 = 7'(w1);
        px.w2 = 7'(w2);
        return px;
    endfunction

    function automatic t_fade_target mk_target(int h, int s, int b, int w1, int w2,
                                               t_stamp start, t_stamp dur);
        t_fade_target t;
        t.hue = 9'(h);
        t.sat = 7'(s);
        t.bri = 7'(b);
        t.w1 = 7'(w1);
        t.w2 = 7'(w2);
        t.start = start;
        t.dur = dur;
        return t;
    endfunction

    function automatic logic [6:0] rand_level();
        return 7'(($urandom_range(0, 11) == 0) ? $urandom_range(101, 127)
                                               : $urandom_range(0, 100));
    endfunction

    function automatic t_stamp rand_stamp();
        t_stamp s;
        case ($urandom_range(0, 7))
            0: s = $urandom();
            1: s = live_target.start - $urandom_range(1, 100);
            2: s = live_target.start + live_target.dur - 1 + $urandom_range(0, 2);
            default: s = live_target.start + $urandom_range(0, live_target.dur);
        endcase
        return s;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px.now = rand_stamp();
        case ($urandom_range(0, 9))
            0: px.hue = 9'($urandom_range(360, 511));
            1: px.hue = 9'((live_target.hue + 180 + $urandom_range(0, 1)) % 360);
            default: px.hue = 9'($urandom_range(0, 359));
        endcase
        px.sat = rand_level();
        px.bri = rand_level();
        px.w1 = rand_level();
        px.w2 = rand_level();
        return px;
    endfunction

    function automatic t_fade_target rand_target();
        t_fade_target t;
        t.hue = 9'(($urandom_range(0, 7) == 0) ? $urandom_range(360, 511)
                                               : $urandom_range(0, 359));
        t.sat = rand_level();
        t.bri = rand_level();
        t.w1 = rand_level();
        t.w2 = rand_level();
        case ($urandom_range(0, 3))
            0: t.start = '0;
            1: t.start = TIME_MAX - $urandom_range(0, 1000);
            default: t.start = $urandom();
        endcase
        case ($urandom_range(0, 7))
            0: t.dur = '0;
            1: t.dur = $urandom_range(1, 3);
            2: t.dur = TIME_MAX;
            3: t.dur = $urandom();
            default: t.dur = $urandom_range(100, 5000);
        endcase
        return t;
    endfunction

    // valid is left high so back-to-back writes follow one another without a gap
    task automatic cfg_write(input logic [2:0] idx, input t_stamp data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            hcfi_pkg::REG_TARGET_HUE: live_target.hue = data[8:0];
            hcfi_pkg::REG_TARGET_SAT: live_target.sat = data[6:0];
            hcfi_pkg::REG_TARGET_BRI: live_target.bri = data[6:0];
            hcfi_pkg::REG_TARGET_W1:  live_target.w1 = data[6:0];
            hcfi_pkg::REG_TARGET_W2:  live_target.w2 = data[6:0];
            hcfi_pkg::REG_START_TIME: live_target.start = data;
            hcfi_pkg::REG_DURATION:   live_target.dur = data;
            default: ;
        endcase
    endtask

    task automatic apply_target(input t_fade_target t, input bit poke_spare);
        cfg_write(hcfi_pkg::REG_TARGET_HUE, t_stamp'(t.hue));
        cfg_write(hcfi_pkg::REG_TARGET_SAT, t_stamp'(t.sat));
        cfg_write(hcfi_pkg::REG_TARGET_BRI, t_stamp'(t.bri));
        cfg_write(hcfi_pkg::REG_TARGET_W1, t_stamp'(t.w1));
        cfg_write(hcfi_pkg::REG_TARGET_W2, t_stamp'(t.w2));
        cfg_write(hcfi_pkg::REG_START_TIME, t.start);
        cfg_write(hcfi_pkg::REG_DURATION, t.dur);
        if (poke_spare) cfg_write(REG_SPARE_IDX, t_stamp'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input t_pixel px);
        int gap;
        i_valid           <= 1'b1;
        i_now_time        <= px.now;
        i_from_hue        <= px.hue;
        i_from_saturation <= px.sat;
        i_from_brightness <= px.bri;
        i_from_white_one  <= px.w1;
        i_from_white_two  <= px.w2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_colors.push_back(blend_color(px, live_target));
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_fade_phase(input int n_items);
        apply_target(rand_target(), $urandom_range(0, 3) == 0);
        repeat (n_items) send_pixel(rand_pixel());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Output side: stall bursts, long hold, result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            rx_burst <= 0;
        end else if (rx_holding) begin
            i_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            i_stall  <= 1'b1;
            rx_burst <= rx_burst - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            i_stall  <= 1'b1;
            rx_burst <= $urandom_range(0, 10);
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial forever begin
        @(rx_hold_go);
        rx_holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_holding = 1'b0;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_color want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_colors.size() == 0) begin
                mismatch_count++;
                $error("result transaction with no input pending");
            end else begin
                want = pending_colors.pop_front();
                check_field("out_hue", want.hue, o_out_hue);
                check_field("out_saturation", want.sat, o_out_saturation);
                check_field("out_brightness", want.bri, o_out_brightness);
                check_field("out_white_one", want.w1, o_out_white_one);
                check_field("out_white_two", want.w2, o_out_white_two);
                check_field("completed", want.done, o_completed);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // all targets, start and duration are zero out of reset: every pixel lands on black
    task automatic test_reset_defaults();
        send_pixel(mk_pixel('0, 359, 100, 100, 100, 100));
        send_pixel(mk_pixel(TIME_MAX, 180, 55, 1, 99, 0));
        wait_drained();
    endtask

    task automatic test_fade_extremes();
        apply_target(mk_target(359, 100, 100, 100, 100, 1000, 1000), 1'b0);
        send_pixel(mk_pixel('0, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(999, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(1000, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(1500, 0, 0, 0, 0, 0));    // half way, hue crosses zero
        send_pixel(mk_pixel(1999, 0, 100, 0, 100, 0));
        send_pixel(mk_pixel(2000, 0, 0, 0, 0, 0));    // at end, not yet completed
        send_pixel(mk_pixel(2001, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(TIME_MAX, 359, 100, 100, 100, 100));
        wait_drained();
    endtask

    task automatic test_hue_short_path();
        apply_target(mk_target(10, 50, 50, 50, 50, '0, 100), 1'b0);
        send_pixel(mk_pixel(50, 200, 0, 100, 0, 100));
        send_pixel(mk_pixel(50, 190, 0, 100, 0, 100));
        send_pixel(mk_pixel(50, 191, 0, 100, 0, 100));
        wait_drained();
        apply_target(mk_target(350, 0, 100, 0, 100, '0, 100), 1'b0);
        send_pixel(mk_pixel(50, 170, 100, 0, 100, 0));
        send_pixel(mk_pixel(50, 169, 100, 0, 100, 0));
        wait_drained();
    endtask

    task automatic test_time_extremes();
        // zero duration at the top of the time range
        apply_target(mk_target(120, 30, 60, 90, 10, TIME_MAX, '0), 1'b0);
        send_pixel(mk_pixel(TIME_MAX, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(TIME_MAX - 1, 0, 0, 0, 0, 0));
        wait_drained();
        // end time beyond the time range
        apply_target(mk_target(240, 100, 0, 100, 0, 1, TIME_MAX), 1'b0);
        send_pixel(mk_pixel('0, 60, 0, 100, 0, 100));
        send_pixel(mk_pixel(TIME_MAX, 60, 0, 100, 0, 100));
        wait_drained();
        apply_target(mk_target(0, 0, 0, 0, 0, '0, TIME_MAX), 1'b0);
        send_pixel(mk_pixel(TIME_MAX, 300, 100, 100, 100, 100));
        wait_drained();
    endtask

    task automatic test_out_of_range_colors();
        apply_target(mk_target(511, 127, 127, 127, 127, '0, 200), 1'b1);
        send_pixel(mk_pixel(100, 0, 0, 0, 0, 0));
        send_pixel(mk_pixel(100, 511, 127, 127, 127, 127));
        send_pixel(mk_pixel(150, 359, 101, 64, 0, 127));
        wait_drained();
    endtask

    task automatic test_random_fades();
        repeat (20) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            run_fade_phase(PHASE_ITEMS);
        end
    endtask

    // receiver holds off while the sender keeps pushing, so the pipe fills and stalls
    task automatic test_backpressure_fill();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_target(rand_target(), 1'b0);
        -> rx_hold_go;
        repeat (PHASE_ITEMS) send_pixel(rand_pixel());
        wait_drained();
    endtask

    task automatic test_streaming_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (6) run_fade_phase(PHASE_ITEMS);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_fade_extremes();
        test_hue_short_path();
        test_time_extremes();
        test_out_of_range_colors();
        test_random_fades();
        test_backpressure_fill();
        test_streaming_no_idle();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_colors.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
